>>> rtl/cfr_pkg.sv
// Shared types, protocol bytes and reply formatting for the calibration frame responder.
package cfr_pkg;

	// Frame and command bytes
	localparam logic [7:0] SOF_BYTE  = 8'hCC;
	localparam logic [7:0] HDR_MID   = 8'h99;
	localparam logic [7:0] CMD_PING  = 8'h80;
	localparam logic [7:0] CMD_SETID = 8'h81;
	localparam logic [7:0] CMD_GETID = 8'h84;

	// Reply trailer bytes for the short replies
	localparam logic [7:0] ACK_PING  = 8'h81;
	localparam logic [7:0] ACK_SETID = 8'h80;
	localparam logic [7:0] ERASED    = 8'hFF;

	// Shortest frame that can pass the checks
	localparam int unsigned MIN_FRAME = 7;

	// Index of the final reply byte
	localparam logic [3:0] LAST_SHORT = 4'd6;
	localparam logic [3:0] LAST_LONG  = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_REPLY
	} state_t;

	typedef enum logic [1:0] {
		RK_PING,
		RK_SETID,
		RK_GETID
	} reply_kind_t;

	// Status of the sequencer seen by the top level
	typedef struct packed {
		logic busy;
		logic valid;
		logic last;
	} seq_status_t;

	// Byte idx of the reply of the given kind; a, b, c are the ID bytes sent
	function automatic logic [7:0] reply_byte(input reply_kind_t kind, input logic [3:0] idx,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		logic [7:0] r;
		unique case (idx)
			4'd0: r = SOF_BYTE;
			4'd1: r = HDR_MID;
			4'd2: r = HDR_MID;
			4'd3: r = SOF_BYTE;
			4'd4: r = (kind == RK_GETID) ? 8'h04 : 8'h01;
			4'd5: begin
				unique case (kind)
					RK_PING:  r = CMD_PING;
					RK_SETID: r = CMD_SETID;
					default:  r = CMD_GETID;
				endcase
			end
			4'd6: begin
				unique case (kind)
					RK_PING:  r = ACK_PING;
					RK_SETID: r = ACK_SETID;
					default:  r = a;
				endcase
			end
			4'd7: r = b;
			4'd8: r = c;
			4'd9: r = a ^ b ^ c ^ 8'h80;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/cfr_seq.sv
// Frame check sequencer: walks the receive buffer, keeps the ID, emits the reply.
module cfr_seq #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [$clog2(DEPTH+1)-1:0] len,
	output logic                       rd_en,
	output logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [7:0]                 rd_data,
	output cfr_pkg::seq_status_t       status,
	output logic [7:0]                 tx_byte
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);

	cfr_pkg::state_t      state_q, state_d;
	cfr_pkg::reply_kind_t kind_q, kind_d;

	logic [CW-1:0] len_q;
	logic [CW-1:0] rd_cnt_q;
	logic          vld_s1;
	logic [CW-1:0] idx_s1;
	logic [7:0]    plen_q;
	logic [7:0]    x_q;
	logic [7:0]    cmd_q;
	logic [7:0]    cand_q [3];
	logic [7:0]    id_q [3];
	logic [7:0]    idsum_q;
	logic [3:0]    tx_cnt_q;
	logic [7:0]    ra_q, rb_q, rc_q;

	logic       proc;
	logic [9:0] idx_w;
	logic [9:0] chk_pos;
	logic [9:0] plen_end_d;
	logic       is_chk;
	logic       in_payload;
	logic       m_ping, m_setid, m_getid;
	logic       accept;
	logic [7:0] id_sum;
	logic       id_ok;
	logic [3:0] last_idx;

	// Read issue: one buffer byte per cycle while walking
	assign rd_en   = (state_q == cfr_pkg::ST_WALK) && (rd_cnt_q < len_q);
	assign rd_addr = rd_cnt_q[AW-1:0];

	// Decode of the byte returning from the buffer
	assign proc       = (state_q == cfr_pkg::ST_WALK) && vld_s1;
	assign idx_w      = 10'(idx_s1);
	assign chk_pos    = 10'(plen_q) + 10'd5;
	assign plen_end_d = 10'(rd_data) + 10'd5;
	assign is_chk     = (idx_s1 >= CW'(5)) && (idx_w == chk_pos);
	assign in_payload = (idx_s1 >= CW'(5)) && !is_chk;

	assign m_ping  = (cmd_q == cfr_pkg::CMD_PING)  && (plen_q == 8'd1);
	assign m_setid = (cmd_q == cfr_pkg::CMD_SETID) && (plen_q == 8'd4);
	assign m_getid = (cmd_q == cfr_pkg::CMD_GETID) && (plen_q == 8'd1);
	assign accept  = (x_q == rd_data) && (m_ping || m_setid || m_getid);

	assign id_sum = id_q[0] + id_q[1] + id_q[2];
	assign id_ok  = (id_sum == idsum_q);

	assign last_idx = (kind_q == cfr_pkg::RK_GETID) ? cfr_pkg::LAST_LONG : cfr_pkg::LAST_SHORT;

	// Next state
	always_comb begin
		state_d = state_q;
		priority if (m_ping) begin
			kind_d = cfr_pkg::RK_PING;
		end else if (m_setid) begin
			kind_d = cfr_pkg::RK_SETID;
		end else begin
			kind_d = cfr_pkg::RK_GETID;
		end
		unique case (state_q)
			cfr_pkg::ST_IDLE: begin
				if (go) begin
					state_d = cfr_pkg::ST_WALK;
				end
			end
			cfr_pkg::ST_WALK: begin
				if (proc) begin
					priority if (idx_s1 == CW'(0) && rd_data != cfr_pkg::SOF_BYTE) begin
						state_d = cfr_pkg::ST_IDLE;
					end else if (idx_s1 == CW'(4) && plen_end_d >= 10'(len_q)) begin
						state_d = cfr_pkg::ST_IDLE;
					end else if (is_chk) begin
						state_d = accept ? cfr_pkg::ST_REPLY : cfr_pkg::ST_IDLE;
					end else begin
						state_d = cfr_pkg::ST_WALK;
					end
				end
			end
			cfr_pkg::ST_REPLY: begin
				if (tx_cnt_q == last_idx) begin
					state_d = cfr_pkg::ST_IDLE;
				end
			end
			default: state_d = cfr_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cfr_pkg::ST_IDLE;
			kind_q   <= cfr_pkg::RK_PING;
			vld_s1   <= 1'b0;
			rd_cnt_q <= '0;
			tx_cnt_q <= '0;
			id_q[0]  <= cfr_pkg::ERASED;
			id_q[1]  <= cfr_pkg::ERASED;
			id_q[2]  <= cfr_pkg::ERASED;
			idsum_q  <= cfr_pkg::ERASED;
		end else begin
			state_q <= state_d;
			// no read is issued while idle, so a new walk starts with nothing in flight
			vld_s1  <= rd_en;
			if (go && state_q == cfr_pkg::ST_IDLE) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (state_q == cfr_pkg::ST_REPLY) begin
				tx_cnt_q <= tx_cnt_q + 4'd1;
			end
			// Accepted frame: start reply, commit a new ID on a set-ID command
			if (proc && state_d == cfr_pkg::ST_REPLY) begin
				kind_q   <= kind_d;
				tx_cnt_q <= '0;
				if (kind_d == cfr_pkg::RK_SETID) begin
					id_q[0] <= cand_q[0];
					id_q[1] <= cand_q[1];
					id_q[2] <= cand_q[2];
					idsum_q <= cand_q[0] + cand_q[1] + cand_q[2];
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (go && state_q == cfr_pkg::ST_IDLE) begin
			len_q <= len;
		end
		idx_s1 <= rd_cnt_q;
		if (proc) begin
			if (idx_s1 == CW'(4)) begin
				plen_q <= rd_data;
				x_q    <= rd_data;
			end
			if (in_payload) begin
				x_q <= x_q ^ rd_data;
				if (idx_s1 == CW'(5)) begin
					cmd_q <= rd_data;
				end
				if (idx_s1 == CW'(6)) begin
					cand_q[0] <= rd_data;
				end
				if (idx_s1 == CW'(7)) begin
					cand_q[1] <= rd_data;
				end
				if (idx_s1 == CW'(8)) begin
					cand_q[2] <= rd_data;
				end
			end
		end
		// ID bytes for a read-back reply, erased if the sum check fails
		if (proc && state_d == cfr_pkg::ST_REPLY) begin
			ra_q <= id_ok ? id_q[0] : cfr_pkg::ERASED;
			rb_q <= id_ok ? id_q[1] : cfr_pkg::ERASED;
			rc_q <= id_ok ? id_q[2] : cfr_pkg::ERASED;
		end
	end

	// Reply output
	assign status.busy  = (state_q != cfr_pkg::ST_IDLE);
	assign status.valid = (state_q == cfr_pkg::ST_REPLY);
	assign status.last  = status.valid && (tx_cnt_q == last_idx);
	assign tx_byte      = cfr_pkg::reply_byte(kind_q, tx_cnt_q, ra_q, rb_q, rc_q);

endmodule

>>> rtl/calibration_frame_responder.sv
// Top level: receive byte capture into the frame buffer and the frame check sequencer.
//
// Channel   Direction  Handshake                Payload
// input     in         start & !busy            mode, data_byte
// reply     out        valid (one cycle each)   tx_byte, last
//
// A received byte (mode 0) is stored while the buffer has room; busy stays low.
// A gap item (mode 1) with fewer than 7 bytes held ends in its transfer cycle.
// Otherwise it walks the buffer through its one read port, one byte per cycle,
// and if the frame is accepted sends 7 or 10 reply bytes on consecutive cycles.
// busy rises after the gap transfer and stays high until the walk ends or the last reply byte is sent.
// Reset clears the byte count, the state and sets the stored ID to erased;
// the buffer needs no clearing. The receiver cannot stall a reply.
module calibration_frame_responder #(
	parameter int unsigned RX_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       mode,
	input  logic [7:0] data_byte,
	output logic       valid,
	output logic [7:0] tx_byte,
	output logic       last
);

	localparam int unsigned CW = $clog2(RX_DEPTH + 1);
	localparam int unsigned AW = $clog2(RX_DEPTH);

	cfr_pkg::seq_status_t status;

	logic [CW-1:0] cnt_q;
	logic          take;
	logic          wr_en;
	logic          go;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign take  = start && !busy;
	assign wr_en = take && !mode && (cnt_q < CW'(RX_DEPTH));
	assign go    = take && mode && (cnt_q >= CW'(cfr_pkg::MIN_FRAME));

	// Byte count: saturates at the buffer depth, cleared by every gap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take && mode) begin
			cnt_q <= '0;
		end else if (wr_en) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	cfr_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_rx_buf (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_q[AW-1:0]),
		.wdata(data_byte),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	cfr_seq #(
		.DEPTH(RX_DEPTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.len    (cnt_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.status (status),
		.tx_byte(tx_byte)
	);

	assign busy  = status.busy;
	assign valid = status.valid;
	assign last  = status.last;

	// Replies only go out while the block holds off input
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n) valid |-> busy)
		else $error("reply byte while not busy");

	// A reply frame ends the work on that item
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n) (valid && last) |=> !busy)
		else $error("still busy after final reply byte");

	// The count never passes the buffer depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(RX_DEPTH))
		else $error("byte count beyond buffer depth");

	// No byte is written into the buffer during a frame walk
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !wr_en)
		else $error("buffer write during frame walk");

endmodule
